// ===== src/qtt_pkg.sv =====
package qtt_pkg;

  localparam int unsigned DefTableDepth = 16;
  localparam int unsigned MaxResults = 16;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_WRITE_REPLY = 2'd1,
    OP_READ_REPLY = 2'd2,
    OP_TICK = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    OUT_SUCCESS = 2'd0,
    OUT_TIMEOUT = 2'd1,
    OUT_REJECTED = 2'd2
  } outcome_t;

  localparam logic [1:0] KIND_READ = 2'd1;

  localparam logic [0:0] REG_QUORUM = 1'b0;
  localparam logic [0:0] REG_WAIT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_APPLY,
    ST_EMIT
  } state_t;

endpackage

// ===== src/qtt_ram.sv =====
module qtt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/quorum_transaction_tracker_core.sv =====
// Pending quorum transaction table. Each input transfer is handled one at a time.
// A start waits in the scan state while a rejected result waits on out_stall. A
// reply or a tick walks the table one slot at a time through the slot memory read
// port, with a read state and an apply state per slot. A reply finishes early on
// a match with reply_ok set. A tick passes through the emit state on each expiry,
// and once more when the last slot expires. Each timed-out result is held back
// until the next expiry or the end of the scan, so that last can be set. The
// block waits in the scan or emit state while the output register holds a result
// stalled by out_stall. in_stall is high whenever the block is busy. Results are
// driven from an output register.
module quorum_transaction_tracker_core
  import qtt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [31:0] trans_id,
  input  logic [1:0]  op_kind,
  input  logic [31:0] key_handle,
  input  logic [31:0] value_handle,
  input  logic        reply_ok,
  input  logic [31:0] reply_timestamp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] done_id,
  output logic [1:0]  done_kind,
  output logic [1:0]  outcome,
  output logic [31:0] done_key,
  output logic [31:0] done_value,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RamW = 32 + 2 + 32 + 32 + 32 + 3 + 32;
  localparam int unsigned ResW = $clog2(MaxResults + 1);

  state_t state, state_next;

  logic [2:0]  quorum_needed;
  logic [15:0] wait_ticks;
  logic [31:0] now_ticks;
  logic [TABLE_DEPTH-1:0] slot_valid;

  logic [1:0]  op;
  logic [31:0] id_r, key_r, val_r, stamp_r;
  logic [1:0]  kind_r;
  logic        ok_r;
  logic [CntW-1:0] idx;
  logic [ResW-1:0] nres;
  logic        found;

  logic        held_valid;
  logic [31:0] held_id, held_key, held_value;
  logic [1:0]  held_kind;

  logic        out_free;
  logic        out_load;
  logic        nres_full;

  logic [IdxW-1:0] free_idx;
  logic            any_free;

  logic        ram_we;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  logic [RamW-1:0] ram_wdata, ram_rdata;

  logic [31:0] r_id, r_key, r_value, r_stamp, r_start;
  logic [1:0]  r_kind;
  logic [2:0]  r_rem;

  assign {r_id, r_kind, r_key, r_value, r_stamp, r_rem, r_start} = ram_rdata;

  qtt_ram #(.Width(RamW), .Depth(TABLE_DEPTH)) u_slots (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic [IdxW-1:0] slot;
  assign slot = idx[IdxW-1:0];
  assign ram_raddr = slot;
  assign ram_waddr = (state == ST_SCAN) ? free_idx : slot;

  // apply-stage decisions
  logic [2:0]  rem_dec;
  logic        take_new;
  logic [31:0] new_val, new_stamp;
  logic        expired;
  logic        match;
  logic [31:0] age;

  assign rem_dec = r_rem - 3'd1;
  assign take_new = (op == OP_READ_REPLY) && (stamp_r >= r_stamp);
  assign new_val = take_new ? val_r : r_value;
  assign new_stamp = take_new ? stamp_r : r_stamp;
  assign age = now_ticks - r_start;
  assign expired = slot_valid[slot] && (age > {16'd0, wait_ticks});
  assign match = slot_valid[slot] && (r_id == id_r);

  logic scan_free_hit, scan_done_all;
  assign scan_free_hit = !slot_valid[slot];
  assign scan_done_all = (idx == CntW'(TABLE_DEPTH - 1));

  assign out_free = !out_valid || !out_stall;
  assign nres_full = (nres + 1'b1 == ResW'(MaxResults));
  assign out_load = (state == ST_SCAN && op == OP_START && !any_free && out_free) ||
                    (state == ST_EMIT && out_free &&
                     ((op == OP_TICK) ? held_valid : found));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_SCAN;
      ST_SCAN: begin
        if (op != OP_START) state_next = ST_READ;
        else if (any_free || out_free) state_next = ST_IDLE;
      end
      ST_READ: state_next = ST_APPLY;
      ST_APPLY: begin
        if (op == OP_TICK) begin
          if (expired && nres < ResW'(MaxResults)) state_next = ST_EMIT;
          else if (scan_done_all) state_next = ST_EMIT;
          else state_next = ST_READ;
        end else begin
          if ((match && ok_r) || scan_done_all) state_next = ST_EMIT;
          else state_next = ST_READ;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (op == OP_TICK && found) begin
            if (scan_done_all || nres_full) state_next = ST_EMIT;
            else state_next = ST_READ;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // found marks a pending expiry for the emit stage on a tick, or a reached quorum on a reply
  always_comb begin
    ram_we = 1'b0;
    ram_wdata = {r_id, r_kind, r_key, new_val, new_stamp, rem_dec, r_start};
    if (state == ST_SCAN && op == OP_START && any_free) begin
      ram_we = 1'b1;
      ram_wdata = {id_r, kind_r, key_r, (kind_r == KIND_READ) ? 32'd0 : val_r, 32'd0,
                   (quorum_needed == 3'd0) ? 3'd1 : quorum_needed, now_ticks};
    end else if (state == ST_APPLY && op != OP_TICK && match && ok_r) begin
      ram_we = 1'b1;
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_QUORUM: prdata = {29'd0, quorum_needed};
      REG_WAIT: prdata = {16'd0, wait_ticks};
      default: prdata = 32'd0;
    endcase
  end

  // free slot search for start runs combinationally over valid bits
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_idx = IdxW'(i);
        any_free = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      quorum_needed <= 3'd2;
      wait_ticks <= 16'd20;
      now_ticks <= '0;
      slot_valid <= '0;
      out_valid <= 1'b0;
      found <= 1'b0;
      held_valid <= 1'b0;
      idx <= '0;
      nres <= '0;
    end else begin
      state <= state_next;
      if (psel && penable && pwrite) begin
        unique case (paddr[2])
          REG_QUORUM: quorum_needed <= pwdata[2:0];
          REG_WAIT: wait_ticks <= pwdata[15:0];
          default: ;
        endcase
      end
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op <= operation;
            id_r <= trans_id;
            kind_r <= op_kind;
            key_r <= key_handle;
            val_r <= value_handle;
            ok_r <= reply_ok;
            stamp_r <= reply_timestamp;
            idx <= '0;
            nres <= '0;
            found <= 1'b0;
            held_valid <= 1'b0;
            if (operation == OP_TICK) now_ticks <= now_ticks + 32'd1;
          end
        end
        ST_SCAN: begin
          if (op == OP_START) begin
            if (any_free) begin
              slot_valid[free_idx] <= 1'b1;
              idx <= CntW'(free_idx);
            end else if (out_free) begin
              done_id <= id_r;
              done_kind <= kind_r;
              outcome <= OUT_REJECTED;
              done_key <= key_r;
              done_value <= val_r;
              last <= 1'b1;
            end
          end
        end
        ST_READ: ;
        ST_APPLY: begin
          if (op == OP_TICK) begin
            if (expired && nres < ResW'(MaxResults)) begin
              found <= 1'b1;
              slot_valid[slot] <= 1'b0;
            end else begin
              found <= 1'b0;
              if (!scan_done_all) idx <= idx + 1'b1;
            end
          end else if (match && ok_r) begin
            found <= (rem_dec == 3'd0);
            if (rem_dec == 3'd0) slot_valid[slot] <= 1'b0;
          end else begin
            found <= 1'b0;
            if (!scan_done_all) idx <= idx + 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (op == OP_TICK) begin
              // the held expiry goes out once the next one or the scan end is known
              if (held_valid) begin
                done_id <= held_id;
                done_kind <= held_kind;
                outcome <= OUT_TIMEOUT;
                done_key <= held_key;
                done_value <= held_value;
                last <= !found;
              end
              if (found) begin
                held_valid <= 1'b1;
                held_id <= r_id;
                held_kind <= r_kind;
                held_key <= r_key;
                held_value <= r_value;
                nres <= nres + 1'b1;
                if (!scan_done_all) idx <= idx + 1'b1;
              end else begin
                held_valid <= 1'b0;
              end
            end else if (found) begin
              done_id <= r_id;
              done_kind <= r_kind;
              done_key <= r_key;
              outcome <= OUT_SUCCESS;
              done_value <= new_val;
              last <= 1'b1;
            end
            found <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== sim/quorum_transaction_tracker_core_test.sv =====
module quorum_transaction_tracker_core_test;
  import qtt_pkg::*;

  localparam int unsigned Depth = DefTableDepth;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned SettleCycles = 60;
  localparam logic [2:0] AddrQuorum = {REG_QUORUM, 2'b00};
  localparam logic [2:0] AddrWait = {REG_WAIT, 2'b00};

  typedef struct {
    logic [31:0] id;
    logic [1:0]  kind;
    logic [1:0]  oc;
    logic [31:0] key;
    logic [31:0] value;
    logic        last;
  } done_rec_t;

  class pending_table_board;
    logic [2:0]  quorum;
    logic [15:0] wait_lim;
    bit          busy_slot [Depth];
    logic [31:0] s_id [Depth];
    logic [1:0]  s_kind [Depth];
    logic [31:0] s_key [Depth];
    logic [31:0] s_value [Depth];
    logic [31:0] s_stamp [Depth];
    logic [2:0]  s_left [Depth];
    logic [31:0] s_start [Depth];
    logic [31:0] now;
    done_rec_t   outstanding [$];
    int          errors;
    int          checked;

    function new();
      quorum = 3'd2;
      wait_lim = 16'd20;
      now = '0;
      errors = 0;
      checked = 0;
      foreach (busy_slot[i]) busy_slot[i] = 0;
    endfunction

    function void set_reg(logic [2:0] addr, logic [31:0] data);
      if (addr == AddrQuorum) quorum = data[2:0];
      else if (addr == AddrWait) wait_lim = data[15:0];
    endfunction

    function void note_transfer(op_t op, logic [31:0] id, logic [1:0] kind,
                                logic [31:0] key, logic [31:0] val, logic ok,
                                logic [31:0] stamp);
      done_rec_t res [$];
      done_rec_t d;
      int hit;
      hit = -1;
      case (op)
        OP_START: begin
          for (int i = 0; i < Depth; i++)
            if (!busy_slot[i] && hit < 0) hit = i;
          if (hit < 0) begin
            d = '{id, kind, OUT_REJECTED, key, val, 1'b0};
            res = {res, d};
          end else begin
            busy_slot[hit] = 1;
            s_id[hit] = id;
            s_kind[hit] = kind;
            s_key[hit] = key;
            s_value[hit] = (kind == KIND_READ) ? 32'd0 : val;
            s_stamp[hit] = '0;
            s_left[hit] = (quorum == 0) ? 3'd1 : quorum;
            s_start[hit] = now;
          end
        end
        OP_WRITE_REPLY, OP_READ_REPLY: begin
          for (int i = 0; i < Depth; i++)
            if (busy_slot[i] && s_id[i] == id && hit < 0) hit = i;
          if (hit >= 0 && ok) begin
            if (op == OP_READ_REPLY && stamp >= s_stamp[hit]) begin
              s_stamp[hit] = stamp;
              s_value[hit] = val;
            end
            s_left[hit] = s_left[hit] - 3'd1;
            if (s_left[hit] == 0) begin
              d = '{s_id[hit], s_kind[hit], OUT_SUCCESS, s_key[hit], s_value[hit], 1'b0};
              res = {res, d};
              busy_slot[hit] = 0;
            end
          end
        end
        default: begin
          now = now + 32'd1;
          for (int i = 0; i < Depth; i++)
            if (busy_slot[i] && res.size() < MaxResults &&
                (now - s_start[i]) > {16'd0, wait_lim}) begin
              d = '{s_id[i], s_kind[i], OUT_TIMEOUT, s_key[i], s_value[i], 1'b0};
              res = {res, d};
              busy_slot[i] = 0;
            end
        end
      endcase
      if (res.size() > 0) res[res.size() - 1].last = 1'b1;
      foreach (res[i]) outstanding = {outstanding, res[i]};
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s mismatch: expected %h, got %h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_transfer(done_rec_t got);
      done_rec_t e;
      if (outstanding.size() == 0) begin
        $error("unexpected result: id %h outcome %0d", got.id, got.oc);
        errors++;
        return;
      end
      e = outstanding.pop_front();
      checked++;
      cmp("done_id", e.id, got.id);
      cmp("done_kind", {30'd0, e.kind}, {30'd0, got.kind});
      cmp("outcome", {30'd0, e.oc}, {30'd0, got.oc});
      cmp("done_key", e.key, got.key);
      cmp("done_value", e.value, got.value);
      cmp("last", {31'd0, e.last}, {31'd0, got.last});
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  operation;
  logic [31:0] trans_id;
  logic [1:0]  op_kind;
  logic [31:0] key_handle;
  logic [31:0] value_handle;
  logic        reply_ok;
  logic [31:0] reply_timestamp;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] done_id;
  logic [1:0]  done_kind;
  logic [1:0]  outcome;
  logic [31:0] done_key;
  logic [31:0] done_value;
  logic        last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pending_table_board board = new();
  int unsigned send_pct;
  int unsigned stall_pct;
  int unsigned idle_count;
  int          sent;
  logic [31:0] live_ids [$];

  quorum_transaction_tracker_core i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    if (!rst && out_valid && !out_stall)
      board.check_transfer('{done_id, done_kind, outcome, done_key, done_value, last});
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= IdleLimit) begin
      $display("timeout: no transfer for %0d cycles", IdleLimit);
      $display("** quorum_transaction_tracker_core: FAILED **");
      $finish;
    end
  end

  task automatic send(op_t op, logic [31:0] id, logic [1:0] kind, logic [31:0] key,
                      logic [31:0] val, logic ok, logic [31:0] stamp);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    trans_id <= id;
    op_kind <= kind;
    key_handle <= key;
    value_handle <= val;
    reply_ok <= ok;
    reply_timestamp <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_transfer(op, id, kind, key, val, ok, stamp);
    sent++;
    if (op == OP_START) begin
      live_ids = {live_ids, id};
      if (live_ids.size() > 24) void'(live_ids.pop_front());
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.outstanding.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    board.set_reg(addr, data);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_item();
    int unsigned pick;
    logic [31:0] id;
    pick = $urandom_range(99);
    id = (live_ids.size() > 0 && $urandom_range(99) < 85) ?
         live_ids[$urandom_range(live_ids.size() - 1)] : $urandom();
    if (pick < 30)
      send(OP_START, $urandom(), 2'($urandom_range(3)), $urandom(), $urandom(),
           1'($urandom_range(1)), $urandom());
    else if (pick < 55)
      send(OP_WRITE_REPLY, id, 2'($urandom_range(3)), $urandom(), $urandom(),
           $urandom_range(99) < 85, $urandom());
    else if (pick < 82)
      send(OP_READ_REPLY, id, 2'($urandom_range(3)), $urandom(), $urandom(),
           $urandom_range(99) < 85, ($urandom_range(3) == 0) ? 32'd0 : $urandom());
    else
      send(OP_TICK, $urandom(), 2'($urandom_range(3)), $urandom(), $urandom(),
           1'($urandom_range(1)), $urandom());
  endtask

  initial begin
    logic [2:0]  q_set [5] = '{3'd1, 3'd7, 3'd0, 3'd3, 3'd5};
    logic [15:0] w_set [5] = '{16'd1, 16'hffff, 16'd3, 16'd6, 16'd12};
    rst <= 1'b1;
    in_valid <= 1'b0;
    operation <= OP_TICK;
    trans_id <= '0;
    op_kind <= '0;
    key_handle <= '0;
    value_handle <= '0;
    reply_ok <= 1'b0;
    reply_timestamp <= '0;
    out_stall <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    send_pct = 0;
    stall_pct = 0;
    sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: full table, rejection, reply corners, mass expiry
    reg_write(AddrQuorum, 32'd2);
    reg_write(AddrWait, 32'd2);
    send(OP_START, 32'h0, 2'd0, 32'h0, 32'h0, 1'b0, 32'h0);
    send(OP_START, 32'hffffffff, KIND_READ, 32'hffffffff, 32'hffffffff, 1'b1, 32'hffffffff);
    send(OP_START, 32'h0, 2'd3, 32'h5a5a5a5a, 32'ha5a5a5a5, 1'b0, 32'h0);
    for (int i = 3; i < Depth; i++)
      send(OP_START, 32'h100 + i, i[1:0], $urandom(), $urandom(), 1'b0, 32'h0);
    send(OP_START, 32'hdeadbeef, 2'd2, 32'hffffffff, 32'hffffffff, 1'b1, 32'h0);
    send(OP_WRITE_REPLY, 32'h0, 2'd0, 32'h0, 32'h0, 1'b0, 32'h0);
    send(OP_WRITE_REPLY, 32'h0, 2'd0, 32'h0, 32'h0, 1'b1, 32'h0);
    send(OP_READ_REPLY, 32'h0, 2'd0, 32'h0, 32'h11111111, 1'b1, 32'h0);
    send(OP_READ_REPLY, 32'hffffffff, 2'd0, 32'h0, 32'h22222222, 1'b1, 32'hffffffff);
    send(OP_READ_REPLY, 32'hffffffff, 2'd0, 32'h0, 32'h33333333, 1'b1, 32'hffffffff);
    send(OP_READ_REPLY, 32'h12345678, 2'd0, 32'h0, 32'h0, 1'b1, 32'h0);
    send(OP_TICK, 32'h0, 2'd0, 32'h0, 32'h0, 1'b0, 32'h0);
    send(OP_TICK, 32'h0, 2'd0, 32'h0, 32'h0, 1'b0, 32'h0);
    send(OP_TICK, 32'h0, 2'd0, 32'h0, 32'h0, 1'b0, 32'h0);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      reg_write(AddrQuorum, 32'(q_set[phase]));
      reg_write(AddrWait, 32'(w_set[phase]));
      send_pct = (phase % 4 == 1) ? 63 : (phase % 4 == 3) ? 7 : 0;
      stall_pct = (phase % 4 == 2) ? 63 : (phase % 4 == 3) ? 7 : 0;
      repeat (56) random_item();
      drain();
    end

    $display("sent %0d transfers over five register settings and four idle patterns",
             sent);
    $display("checked %0d results", board.checked);
    if (board.errors == 0 && board.outstanding.size() == 0) begin
      $display("** quorum_transaction_tracker_core: PASSED **");
    end else begin
      $display("** quorum_transaction_tracker_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/qtt_pkg.sv
src/qtt_ram.sv
src/quorum_transaction_tracker_core.sv
sim/quorum_transaction_tracker_core_test.sv
